@@ sv/bw_pkg.sv @@
// ----------------------------------------------------------------------------
// bw_pkg - shared definitions for the barycentric weight pipeline
// Widths of every intermediate, lane and dot-product bundles, saturation.
// ----------------------------------------------------------------------------
package bw_pkg;

  localparam int COORD_W   = 32;
  localparam int FRAC_BITS = 16;
  localparam int OUT_W     = 32;
  localparam int EDGE_W    = COORD_W + 1;
  localparam int PROD_W    = 2 * EDGE_W;
  localparam int DOT_W     = PROD_W + 2;
  localparam int HALF_W    = DOT_W / 2;
  localparam int MUL_W     = 2 * DOT_W;
  localparam int NUM_W     = MUL_W + 1;
  localparam int DVS_W     = NUM_W;
  localparam int DVD_W     = NUM_W + FRAC_BITS;
  localparam int DIV_STAGES = DVD_W;
  localparam int SQ_W      = DVD_W + 1;
  localparam int SUM_W     = SQ_W + 2;

  // stages ahead of the divider: diff, product, merge, mul x2, combine x2
  localparam int FRONT_STAGES = 7;
  localparam int PIPE_STAGES  = FRONT_STAGES + DIV_STAGES;

  localparam int DIM_W = 2;
  localparam logic [DIM_W-1:0] DIM_2D    = 2'd2;
  localparam logic [DIM_W-1:0] DIM_RESET = 2'd3;

  localparam int ADDR_W = 3;
  localparam logic REG_DIMENSIONS = 1'b0;

  localparam logic signed [SUM_W-1:0] ONE_Q   = SUM_W'(1) << FRAC_BITS;
  localparam logic signed [SUM_W-1:0] SAT_MAX = (SUM_W'(1) << (OUT_W - 1)) - SUM_W'(1);
  localparam logic signed [SUM_W-1:0] SAT_MIN = -(SUM_W'(1) << (OUT_W - 1));

  typedef struct packed {
    logic signed [PROD_W-1:0] p00;
    logic signed [PROD_W-1:0] p01;
    logic signed [PROD_W-1:0] p11;
    logic signed [PROD_W-1:0] p20;
    logic signed [PROD_W-1:0] p21;
  } bw_prod_t;

  typedef struct packed {
    logic signed [DOT_W-1:0] d00;
    logic signed [DOT_W-1:0] d01;
    logic signed [DOT_W-1:0] d11;
    logic signed [DOT_W-1:0] d20;
    logic signed [DOT_W-1:0] d21;
  } bw_dot_t;

  function automatic logic [OUT_W-1:0] sat_w(input logic signed [SUM_W-1:0] x);
    logic [OUT_W-1:0] r;
    if (x > SAT_MAX) begin
      r = OUT_W'(SAT_MAX);
    end else if (x < SAT_MIN) begin
      r = OUT_W'(SAT_MIN);
    end else begin
      r = OUT_W'(x);
    end
    return r;
  endfunction

endpackage

@@ sv/bw_lane.sv @@
// ----------------------------------------------------------------------------
// bw_lane - one coordinate lane
// Edge differences of one axis, then the five per-axis products.
// ----------------------------------------------------------------------------
module bw_lane (
  input  logic                              clk,
  input  logic                              ce,
  input  logic signed [bw_pkg::COORD_W-1:0] a,
  input  logic signed [bw_pkg::COORD_W-1:0] b,
  input  logic signed [bw_pkg::COORD_W-1:0] c,
  input  logic signed [bw_pkg::COORD_W-1:0] p,
  output bw_pkg::bw_prod_t                  prod_r
);

  logic signed [bw_pkg::EDGE_W-1:0] e0_r;
  logic signed [bw_pkg::EDGE_W-1:0] e1_r;
  logic signed [bw_pkg::EDGE_W-1:0] e2_r;

  always_ff @(posedge clk) begin
    if (ce) begin
      e0_r <= bw_pkg::EDGE_W'(b) - bw_pkg::EDGE_W'(a);
      e1_r <= bw_pkg::EDGE_W'(c) - bw_pkg::EDGE_W'(a);
      e2_r <= bw_pkg::EDGE_W'(p) - bw_pkg::EDGE_W'(a);
      prod_r.p00 <= bw_pkg::PROD_W'(e0_r) * bw_pkg::PROD_W'(e0_r);
      prod_r.p01 <= bw_pkg::PROD_W'(e0_r) * bw_pkg::PROD_W'(e1_r);
      prod_r.p11 <= bw_pkg::PROD_W'(e1_r) * bw_pkg::PROD_W'(e1_r);
      prod_r.p20 <= bw_pkg::PROD_W'(e2_r) * bw_pkg::PROD_W'(e0_r);
      prod_r.p21 <= bw_pkg::PROD_W'(e2_r) * bw_pkg::PROD_W'(e1_r);
    end
  end

endmodule

@@ sv/bw_merge.sv @@
// ----------------------------------------------------------------------------
// bw_merge - lane merge
// Sums the per-axis products into the five dot products.
// ----------------------------------------------------------------------------
module bw_merge (
  input  logic             clk,
  input  logic             ce,
  input  logic             use_z,
  input  bw_pkg::bw_prod_t lane_x,
  input  bw_pkg::bw_prod_t lane_y,
  input  bw_pkg::bw_prod_t lane_z,
  output bw_pkg::bw_dot_t  dot_r
);

  bw_pkg::bw_prod_t lz;

  // drop the z lane in the two-coordinate form
  assign lz = use_z ? lane_z : '0;

  always_ff @(posedge clk) begin
    if (ce) begin
      dot_r.d00 <= bw_pkg::DOT_W'(lane_x.p00) + bw_pkg::DOT_W'(lane_y.p00)
                 + bw_pkg::DOT_W'(lz.p00);
      dot_r.d01 <= bw_pkg::DOT_W'(lane_x.p01) + bw_pkg::DOT_W'(lane_y.p01)
                 + bw_pkg::DOT_W'(lz.p01);
      dot_r.d11 <= bw_pkg::DOT_W'(lane_x.p11) + bw_pkg::DOT_W'(lane_y.p11)
                 + bw_pkg::DOT_W'(lz.p11);
      dot_r.d20 <= bw_pkg::DOT_W'(lane_x.p20) + bw_pkg::DOT_W'(lane_y.p20)
                 + bw_pkg::DOT_W'(lz.p20);
      dot_r.d21 <= bw_pkg::DOT_W'(lane_x.p21) + bw_pkg::DOT_W'(lane_y.p21)
                 + bw_pkg::DOT_W'(lz.p21);
    end
  end

endmodule

@@ sv/bw_mul.sv @@
// ----------------------------------------------------------------------------
// bw_mul - two-stage signed multiplier for dot products
// Four half-width partial products, then a shifted sum.
// ----------------------------------------------------------------------------
module bw_mul (
  input  logic                            clk,
  input  logic                            ce,
  input  logic signed [bw_pkg::DOT_W-1:0] a,
  input  logic signed [bw_pkg::DOT_W-1:0] b,
  output logic signed [bw_pkg::MUL_W-1:0] p_r
);

  localparam int HW = bw_pkg::HALF_W;

  logic signed [HW-1:0]   a_hi;
  logic signed [HW-1:0]   b_hi;
  logic signed [HW:0]     a_lo;
  logic signed [HW:0]     b_lo;
  logic signed [2*HW-1:0] hh_r;
  logic signed [2*HW:0]   hl_r;
  logic signed [2*HW:0]   lh_r;
  logic [2*HW-1:0]        ll_r;

  assign a_hi = a[bw_pkg::DOT_W-1:HW];
  assign b_hi = b[bw_pkg::DOT_W-1:HW];
  assign a_lo = {1'b0, a[HW-1:0]};
  assign b_lo = {1'b0, b[HW-1:0]};

  always_ff @(posedge clk) begin
    if (ce) begin
      hh_r <= (2*HW)'(a_hi) * (2*HW)'(b_hi);
      hl_r <= (2*HW+1)'(a_hi) * (2*HW+1)'(b_lo);
      lh_r <= (2*HW+1)'(a_lo) * (2*HW+1)'(b_hi);
      ll_r <= (2*HW)'(a[HW-1:0]) * (2*HW)'(b[HW-1:0]);
      p_r  <= (bw_pkg::MUL_W'(hh_r) << (2*HW)) + (bw_pkg::MUL_W'(hl_r) << HW)
            + (bw_pkg::MUL_W'(lh_r) << HW) + bw_pkg::MUL_W'(ll_r);
    end
  end

endmodule

@@ sv/bw_div.sv @@
// ----------------------------------------------------------------------------
// bw_div - pipelined restoring divider
// One quotient bit per stage on unsigned magnitudes; sign rides along.
// ----------------------------------------------------------------------------
module bw_div (
  input  logic                      clk,
  input  logic                      ce,
  input  logic [bw_pkg::DVD_W-1:0]  dvd,
  input  logic [bw_pkg::DVS_W-1:0]  dvs,
  input  logic                      neg,
  output logic [bw_pkg::DVD_W-1:0]  quo,
  output logic                      quo_neg
);

  localparam int NS = bw_pkg::DIV_STAGES;

  logic [bw_pkg::DVS_W-1:0] rem_r [NS];
  logic [bw_pkg::DVS_W-1:0] dvs_r [NS];
  logic [bw_pkg::DVD_W-1:0] dvd_r [NS];
  logic [bw_pkg::DVD_W-1:0] quo_r [NS];
  logic                     neg_r [NS];

  for (genvar k = 0; k < NS; k++) begin : g_stage
    logic [bw_pkg::DVS_W-1:0] rem_in;
    logic [bw_pkg::DVS_W-1:0] dvs_in;
    logic [bw_pkg::DVD_W-1:0] dvd_in;
    logic [bw_pkg::DVD_W-1:0] quo_in;
    logic                     neg_in;
    logic [bw_pkg::DVS_W:0]   trial;
    logic [bw_pkg::DVS_W+1:0] diff;

    if (k == 0) begin : g_first
      assign rem_in = '0;
      assign dvs_in = dvs;
      assign dvd_in = dvd;
      assign quo_in = '0;
      assign neg_in = neg;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign dvs_in = dvs_r[k-1];
      assign dvd_in = dvd_r[k-1];
      assign quo_in = quo_r[k-1];
      assign neg_in = neg_r[k-1];
    end

    assign trial = {rem_in, dvd_in[bw_pkg::DVD_W-1]};
    assign diff  = {1'b0, trial} - {2'b00, dvs_in};

    always_ff @(posedge clk) begin
      if (ce) begin
        // keep the difference when no borrow came out
        if (!diff[bw_pkg::DVS_W+1]) begin
          rem_r[k] <= diff[bw_pkg::DVS_W-1:0];
          quo_r[k] <= {quo_in[bw_pkg::DVD_W-2:0], 1'b1};
        end else begin
          rem_r[k] <= trial[bw_pkg::DVS_W-1:0];
          quo_r[k] <= {quo_in[bw_pkg::DVD_W-2:0], 1'b0};
        end
        dvd_r[k] <= dvd_in << 1;
        dvs_r[k] <= dvs_in;
        neg_r[k] <= neg_in;
      end
    end
  end

  assign quo     = quo_r[NS-1];
  assign quo_neg = neg_r[NS-1];

endmodule

@@ sv/barycentric_weights.sv @@
// ----------------------------------------------------------------------------
// barycentric_weights - barycentric weights by the dot-product method
// Pipeline: 7 front stages, 153 divider stages and an output register,
//   its depth set by the one-bit-per-stage divider.
// Throughput: one transaction per cycle, every stage fully pipelined; a stall
//   on the output holds the whole pipeline.
// Reset: clears all valid bits and sets dimensions to 3.
// ----------------------------------------------------------------------------
module barycentric_weights (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, p_x, p_y, p_z (32 b each)
  input  logic [12*bw_pkg::COORD_W-1:0] in_tdata,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  // weight_u, weight_v, weight_w (32 b each)
  output logic [3*bw_pkg::OUT_W-1:0] out_tdata,
  // degenerate
  output logic                      out_tuser,
  input  logic                      cfg_psel,
  input  logic                      cfg_penable,
  input  logic                      cfg_pwrite,
  input  logic [bw_pkg::ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]               cfg_pwdata,
  output logic [31:0]               cfg_prdata,
  output logic                      cfg_pready
);

  localparam int CW = bw_pkg::COORD_W;
  localparam int NS = bw_pkg::DIV_STAGES;
  localparam int PS = bw_pkg::PIPE_STAGES;

  logic                         ce;
  logic                         in_acc;
  logic [bw_pkg::DIM_W-1:0]     dims_r;
  logic [PS-1:0]                vld_r;
  logic [NS-1:0]                degen_dly_r;
  logic                         out_valid_r;
  logic [3*bw_pkg::OUT_W-1:0]   out_data_r;
  logic                         out_degen_r;

  bw_pkg::bw_prod_t lane_x;
  bw_pkg::bw_prod_t lane_y;
  bw_pkg::bw_prod_t lane_z;
  bw_pkg::bw_dot_t  dot;

  logic signed [bw_pkg::MUL_W-1:0] m00_11, m01_01, m11_20, m01_21, m00_21, m01_20;
  logic signed [bw_pkg::NUM_W-1:0] den_r, nv_r, nw_r;

  logic [bw_pkg::DVS_W-1:0] dvs_nxt, dvs_r;
  logic [bw_pkg::DVD_W-1:0] dvd_v_nxt, dvd_v_r, dvd_w_nxt, dvd_w_r;
  logic                     neg_v_r, neg_w_r, degen_r, degen_nxt;
  logic [bw_pkg::NUM_W-1:0] nv_abs, nw_abs;

  logic [bw_pkg::DVD_W-1:0] quo_v, quo_w;
  logic                     qneg_v, qneg_w;
  logic signed [bw_pkg::SQ_W-1:0]  vq_mag, wq_mag, vq, wq;
  logic signed [bw_pkg::SUM_W-1:0] uq;

  // advance only when the output register is free or being drained
  assign ce         = !out_valid_r || out_tready;
  assign in_tready  = ce;
  assign in_acc     = in_tvalid && ce;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == bw_pkg::REG_DIMENSIONS) ? 32'(dims_r) : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dims_r <= bw_pkg::DIM_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite
                 && cfg_paddr[2] == bw_pkg::REG_DIMENSIONS) begin
      dims_r <= cfg_pwdata[bw_pkg::DIM_W-1:0];
    end
  end

  bw_lane u_lane_x (
    .clk(clk), .ce(ce),
    .a(in_tdata[0*CW +: CW]), .b(in_tdata[3*CW +: CW]),
    .c(in_tdata[6*CW +: CW]), .p(in_tdata[9*CW +: CW]), .prod_r(lane_x)
  );
  bw_lane u_lane_y (
    .clk(clk), .ce(ce),
    .a(in_tdata[1*CW +: CW]), .b(in_tdata[4*CW +: CW]),
    .c(in_tdata[7*CW +: CW]), .p(in_tdata[10*CW +: CW]), .prod_r(lane_y)
  );
  bw_lane u_lane_z (
    .clk(clk), .ce(ce),
    .a(in_tdata[2*CW +: CW]), .b(in_tdata[5*CW +: CW]),
    .c(in_tdata[8*CW +: CW]), .p(in_tdata[11*CW +: CW]), .prod_r(lane_z)
  );

  bw_merge u_merge (
    .clk(clk), .ce(ce), .use_z(dims_r != bw_pkg::DIM_2D),
    .lane_x(lane_x), .lane_y(lane_y), .lane_z(lane_z), .dot_r(dot)
  );

  bw_mul u_mul_den0 (.clk(clk), .ce(ce), .a(dot.d00), .b(dot.d11), .p_r(m00_11));
  bw_mul u_mul_den1 (.clk(clk), .ce(ce), .a(dot.d01), .b(dot.d01), .p_r(m01_01));
  bw_mul u_mul_nv0  (.clk(clk), .ce(ce), .a(dot.d11), .b(dot.d20), .p_r(m11_20));
  bw_mul u_mul_nv1  (.clk(clk), .ce(ce), .a(dot.d01), .b(dot.d21), .p_r(m01_21));
  bw_mul u_mul_nw0  (.clk(clk), .ce(ce), .a(dot.d00), .b(dot.d21), .p_r(m00_21));
  bw_mul u_mul_nw1  (.clk(clk), .ce(ce), .a(dot.d01), .b(dot.d20), .p_r(m01_20));

  always_ff @(posedge clk) begin
    if (ce) begin
      den_r <= bw_pkg::NUM_W'(m00_11) - bw_pkg::NUM_W'(m01_01);
      nv_r  <= bw_pkg::NUM_W'(m11_20) - bw_pkg::NUM_W'(m01_21);
      nw_r  <= bw_pkg::NUM_W'(m00_21) - bw_pkg::NUM_W'(m01_20);
    end
  end

  always_comb begin
    degen_nxt = (den_r == '0);
    dvs_nxt   = den_r[bw_pkg::NUM_W-1] ? bw_pkg::NUM_W'(-den_r) : bw_pkg::NUM_W'(den_r);
    // substitute one for a zero denominator
    if (degen_nxt) begin
      dvs_nxt = bw_pkg::DVS_W'(1);
    end
    nv_abs    = nv_r[bw_pkg::NUM_W-1] ? bw_pkg::NUM_W'(-nv_r) : bw_pkg::NUM_W'(nv_r);
    nw_abs    = nw_r[bw_pkg::NUM_W-1] ? bw_pkg::NUM_W'(-nw_r) : bw_pkg::NUM_W'(nw_r);
    dvd_v_nxt = {nv_abs, bw_pkg::FRAC_BITS'(0)};
    dvd_w_nxt = {nw_abs, bw_pkg::FRAC_BITS'(0)};
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      dvs_r   <= dvs_nxt;
      dvd_v_r <= dvd_v_nxt;
      dvd_w_r <= dvd_w_nxt;
      neg_v_r <= nv_r[bw_pkg::NUM_W-1] ^ den_r[bw_pkg::NUM_W-1];
      neg_w_r <= nw_r[bw_pkg::NUM_W-1] ^ den_r[bw_pkg::NUM_W-1];
      degen_r <= degen_nxt;
    end
  end

  bw_div u_div_v (
    .clk(clk), .ce(ce), .dvd(dvd_v_r), .dvs(dvs_r), .neg(neg_v_r),
    .quo(quo_v), .quo_neg(qneg_v)
  );
  bw_div u_div_w (
    .clk(clk), .ce(ce), .dvd(dvd_w_r), .dvs(dvs_r), .neg(neg_w_r),
    .quo(quo_w), .quo_neg(qneg_w)
  );

  always_ff @(posedge clk) begin
    if (ce) begin
      degen_dly_r <= {degen_dly_r[NS-2:0], degen_r};
    end
  end

  always_comb begin
    vq_mag = bw_pkg::SQ_W'(quo_v);
    wq_mag = bw_pkg::SQ_W'(quo_w);
    vq     = qneg_v ? -vq_mag : vq_mag;
    wq     = qneg_w ? -wq_mag : wq_mag;
    uq     = bw_pkg::ONE_Q - bw_pkg::SUM_W'(vq) - bw_pkg::SUM_W'(wq);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (ce) begin
      vld_r       <= {vld_r[PS-2:0], in_acc};
      out_valid_r <= vld_r[PS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      out_data_r  <= {bw_pkg::sat_w(bw_pkg::SUM_W'(wq)), bw_pkg::sat_w(bw_pkg::SUM_W'(vq)),
                      bw_pkg::sat_w(uq)};
      out_degen_r <= degen_dly_r[NS-1];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_degen_r;

  a_degen_weights: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_degen_r |->
      out_data_r[bw_pkg::OUT_W +: 2*bw_pkg::OUT_W] == '0
      && out_data_r[bw_pkg::OUT_W-1:0] == bw_pkg::OUT_W'(bw_pkg::ONE_Q))
    else $error("degenerate result with nonzero v or w");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !ce |=> $stable(vld_r))
    else $error("pipeline moved during stall");

endmodule
